// File: rtl/dnrc_pkg.sv
// Package: shared types, constants and command codes of the descriptor matcher.
`default_nettype none
package dnrc_pkg;
  localparam int MaxDescDef = 1024;
  localparam int DimDef = 128;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [2:0] REG_CROSS_CHECK = 3'd0;
  localparam logic [2:0] REG_RATIO_ON    = 3'd1;
  localparam logic [2:0] REG_RATIO_SQ    = 3'd2;
  localparam logic [2:0] REG_COUNT_A     = 3'd3;
  localparam logic [2:0] REG_COUNT_B     = 3'd4;

  localparam logic [15:0] RatioSqReset = 16'd10486;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] desc_index;
    logic [6:0] elem_index;
    logic [7:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [9:0] query_index;
    logic [9:0] match_index;
  } out_item_t;

  // Classified work handed from the front end to the search engine.
  typedef struct packed {
    logic       is_query;
    logic       is_b;
    logic [9:0] desc_index;
    logic [6:0] elem_index;
    logic [7:0] elem_value;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/descriptor_nn_ratio_crosscheck_match_top.sv
// Top level of the brute-force descriptor matcher.
// Load beats are written while the engine is idle. A query sweeps count_b rows of set B at
// one element per cycle, then with cross-check on sweeps count_a rows of set A the
// same way, then forms the ratio product and compares. The single read port of each
// descriptor memory sets the sweep rate. A short queue lets loads and queries arrive
// while a search runs; the result beat is held until taken.
`default_nettype none
module descriptor_nn_ratio_crosscheck_match_top #(
  parameter int MAX_DESC = dnrc_pkg::MaxDescDef,
  parameter int DIM = dnrc_pkg::DimDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dnrc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dnrc_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata
);
  import dnrc_pkg::*;

  logic        cross_check_on;
  logic        ratio_test_on;
  logic [15:0] ratio_sq;
  logic [10:0] count_a;
  logic [10:0] count_b;
  logic        job_valid;
  logic        job_ready;
  job_t        job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_check_on <= 1'b1;
      ratio_test_on  <= 1'b1;
      ratio_sq       <= RatioSqReset;
      count_a        <= '0;
      count_b        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CROSS_CHECK: cross_check_on <= cfg_wdata[0];
        REG_RATIO_ON:    ratio_test_on  <= cfg_wdata[0];
        REG_RATIO_SQ:    ratio_sq       <= cfg_wdata;
        REG_COUNT_A:     count_a        <= cfg_wdata[10:0];
        REG_COUNT_B:     count_b        <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  dnrc_front #(.DEPTH(4)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  dnrc_engine #(.MAX_DESC(MAX_DESC), .DIM(DIM)) u_engine (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .cross_check_on(cross_check_on), .ratio_test_on(ratio_test_on), .ratio_sq(ratio_sq),
    .count_a(count_a), .count_b(count_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// File: rtl/dnrc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module dnrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/dnrc_front.sv
// Front end: accepts input beats, drops meaningless ones, queues the rest.
`default_nettype none
module dnrc_front #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dnrc_pkg::in_item_t in_data,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output dnrc_pkg::job_t        job
);
  import dnrc_pkg::*;
  localparam int AW = $clog2(DEPTH);

  job_t           fifo [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    fill;
  logic           keep;
  logic           push;
  logic           pop;
  job_t           in_job;

  // Command 3 is dropped here and never reaches the engine.
  always_comb begin
    in_job.is_query   = (in_data.command == CMD_QUERY);
    in_job.is_b       = (in_data.command == CMD_LOAD_B);
    in_job.desc_index = in_data.desc_index;
    in_job.elem_index = in_data.elem_index;
    in_job.elem_value = in_data.elem_value;
    keep = (in_data.command != CMD_NOP);
  end

  assign in_ready  = (fill != (AW+1)'(DEPTH));
  assign push      = in_valid && in_ready && keep;
  assign job_valid = (fill != '0);
  assign pop       = job_valid && job_ready;
  assign job       = fifo[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_job;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: rtl/dnrc_engine.sv
// Back end: performs loads and runs the nearest-neighbor search per query.
`default_nettype none
module dnrc_engine #(
  parameter int MAX_DESC = 1024,
  parameter int DIM = 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire dnrc_pkg::job_t     job,
  input  wire logic               cross_check_on,
  input  wire logic               ratio_test_on,
  input  wire logic [15:0]        ratio_sq,
  input  wire logic [10:0]        count_a,
  input  wire logic [10:0]        count_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dnrc_pkg::out_item_t     out_data
);
  import dnrc_pkg::*;
  localparam int RW = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
  localparam int EW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW = RW + EW;
  localparam int DW = $clog2(DIM * 65025 + 1);
  localparam int CW = RW + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FWD   = 4'd1;
  localparam logic [3:0] ST_FWDW  = 4'd2;
  localparam logic [3:0] ST_FWDR  = 4'd3;
  localparam logic [3:0] ST_BCK   = 4'd4;
  localparam logic [3:0] ST_BCKW  = 4'd5;
  localparam logic [3:0] ST_BCKR  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_CMP   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]     state;
  logic [9:0]     qrow;
  logic [CW-1:0]  na;
  logic [CW-1:0]  nb;
  logic [CW-1:0]  row;
  logic [EW:0]    elem;
  logic           have1;
  logic           have2;
  logic [DW-1:0]  d1;
  logic [DW-1:0]  d2;
  logic [DW-1:0]  acc;
  logic [RW-1:0]  best;
  logic [RW-1:0]  back;
  logic           ok;
  logic           rd_pipe;
  logic [DW+15:0] lhs;
  logic [DW+15:0] rhs;
  logic [7:0]     pa;
  logic [7:0]     pb;
  logic [8:0]     diff;
  logic [15:0]    sq;

  logic           a_we;
  logic           b_we;
  logic [AW-1:0]  a_addr;
  logic [AW-1:0]  b_addr;
  logic [7:0]     a_rdata;
  logic [7:0]     b_rdata;
  logic           load_ok;
  logic           is_bck;

  // Rows are addressed as {row, element}, so each store spans the full address range.
  dnrc_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram_a (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(job.elem_value), .rdata(a_rdata)
  );
  dnrc_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram_b (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(job.elem_value), .rdata(b_rdata)
  );

  // Loads are written in the idle state.
  assign job_ready = (state == ST_IDLE);
  assign load_ok   = ({1'b0, job.desc_index} < 11'(MAX_DESC)) &&
                     ({1'b0, job.elem_index} < 8'(DIM));
  assign a_we = job_valid && job_ready && !job.is_query && !job.is_b && load_ok;
  assign b_we = job_valid && job_ready && !job.is_query && job.is_b && load_ok;
  assign is_bck   = (state == ST_BCK) || (state == ST_BCKW) || (state == ST_BCKR);

  // Address muxing: in the forward pass A holds the query row and B is swept,
  // in the backward pass B holds the winner and A is swept.
  always_comb begin
    if (state == ST_IDLE) begin
      a_addr = {job.desc_index[RW-1:0], job.elem_index[EW-1:0]};
      b_addr = a_addr;
    end else if (!is_bck) begin
      a_addr = {qrow[RW-1:0], elem[EW-1:0]};
      b_addr = {row[RW-1:0], elem[EW-1:0]};
    end else begin
      a_addr = {row[RW-1:0], elem[EW-1:0]};
      b_addr = {best, elem[EW-1:0]};
    end
  end

  // One squared element difference per cycle.
  always_comb begin
    pa   = a_rdata;
    pb   = b_rdata;
    diff = {1'b0, pa} - {1'b0, pb};
    if (diff[8]) diff = 9'd0 - diff;
    sq   = diff[7:0] * diff[7:0];
  end

  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pipe <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid && job.is_query) begin
            qrow  <= job.desc_index;
            na    <= (count_a > 11'(MAX_DESC)) ? CW'(MAX_DESC) : CW'(count_a);
            nb    <= (count_b > 11'(MAX_DESC)) ? CW'(MAX_DESC) : CW'(count_b);
            row   <= '0;
            elem  <= '0;
            acc   <= '0;
            have1 <= 1'b0;
            have2 <= 1'b0;
            d1    <= '0;
            d2    <= '0;
            best  <= '0;
            ok    <= 1'b0;
            rd_pipe <= 1'b0;
            if (({1'b0, job.desc_index} < count_a) &&
                ({1'b0, job.desc_index} < 11'(MAX_DESC)) && (count_b != 11'd0)) begin
              state <= ST_FWD;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_FWD, ST_BCK: begin
          // Issue element reads; accumulate each result in the next cycle.
          if (rd_pipe) acc <= acc + DW'(sq);
          rd_pipe <= 1'b1;
          if (elem == (EW+1)'(DIM - 1)) begin
            elem  <= '0;
            state <= (state == ST_FWD) ? ST_FWDW : ST_BCKW;
          end else begin
            elem <= elem + 1'b1;
          end
        end
        ST_FWDW, ST_BCKW: begin
          acc     <= acc + DW'(sq);
          rd_pipe <= 1'b0;
          state   <= (state == ST_FWDW) ? ST_FWDR : ST_BCKR;
        end
        ST_FWDR: begin
          // Update nearest and second nearest for this B row.
          if (!have1 || acc < d1) begin
            if (have1) begin
              have2 <= 1'b1;
              d2    <= d1;
            end
            have1 <= 1'b1;
            d1    <= acc;
            best  <= row[RW-1:0];
          end else if (!have2 || acc < d2) begin
            have2 <= 1'b1;
            d2    <= acc;
          end
          acc <= '0;
          if (row + 1'b1 == nb) begin
            row   <= '0;
            have1 <= 1'b1;
            state <= cross_check_on ? ST_BCK : ST_MUL;
          end else begin
            row   <= row + 1'b1;
            state <= ST_FWD;
          end
        end
        ST_BCKR: begin
          // Track nearest A row to the winning B row; ties keep earlier.
          if (row == '0 || acc < rhs[DW-1:0]) begin
            rhs  <= {16'd0, acc};
            back <= row[RW-1:0];
          end
          acc <= '0;
          if (row + 1'b1 == na) begin
            state <= ST_MUL;
          end else begin
            row   <= row + 1'b1;
            state <= ST_BCK;
          end
        end
        ST_MUL: begin
          // Ratio products, one multiplier.
          lhs   <= {d1, 16'd0};
          rhs   <= (DW+16)'(d2) * (DW+16)'(ratio_sq);
          ok    <= !cross_check_on || (back == qrow[RW-1:0]);
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (ratio_test_on && have2 && (lhs > rhs)) ok <= 1'b0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.matched     = ok;
    out_data.query_index = qrow;
    out_data.match_index = 10'(best);
  end
endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the brute-force descriptor matcher.
`timescale 1ns / 100ps
`default_nettype none

class match_scoreboard;
  // Model copy of both descriptor stores and the register settings.
  logic [7:0]  store_a [int];
  logic [7:0]  store_b [int];
  bit          cross_on;
  bit          ratio_on;
  logic [15:0] ratio_lim;
  int unsigned rows_a;
  int unsigned rows_b;
  dnrc_pkg::out_item_t pending[$];
  int errors;

  function new();
    cross_on = 1;
    ratio_on = 1;
    ratio_lim = dnrc_pkg::RatioSqReset;
    rows_a = 0;
    rows_b = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      dnrc_pkg::REG_CROSS_CHECK: cross_on = val[0];
      dnrc_pkg::REG_RATIO_ON:    ratio_on = val[0];
      dnrc_pkg::REG_RATIO_SQ:    ratio_lim = val;
      dnrc_pkg::REG_COUNT_A:     rows_a = (val[10:0] > 1024) ? 1024 : val[10:0];
      dnrc_pkg::REG_COUNT_B:     rows_b = (val[10:0] > 1024) ? 1024 : val[10:0];
      default: ;
    endcase
  endfunction

  function longint unsigned row_dist(bit q_from_a, int qrow, int crow);
    longint unsigned acc;
    int dv;
    acc = 0;
    for (int k = 0; k < 128; k++) begin
      if (q_from_a) dv = int'(store_a[qrow*128+k]) - int'(store_b[crow*128+k]);
      else dv = int'(store_b[qrow*128+k]) - int'(store_a[crow*128+k]);
      acc += longint'(dv * dv);
    end
    return acc;
  endfunction

  // Nearest and second-nearest search; earlier row wins ties.
  function void nearest(bit q_from_a, int qrow, int n, output int best,
                        output longint unsigned d1, output bit has2,
                        output longint unsigned d2);
    longint unsigned d;
    best = 0; d1 = 0; d2 = 0; has2 = 0;
    for (int i = 0; i < n; i++) begin
      d = row_dist(q_from_a, qrow, i);
      if (i == 0 || d < d1) begin
        if (i != 0) begin
          has2 = 1;
          d2 = d1;
        end
        d1 = d;
        best = i;
      end else if (!has2 || d < d2) begin
        has2 = 1;
        d2 = d;
      end
    end
  endfunction

  function void note_input(dnrc_pkg::in_item_t it);
    dnrc_pkg::out_item_t res;
    int nn, back;
    longint unsigned d1, d2, e1, e2;
    bit h2, g2, ok;
    if (it.command == dnrc_pkg::CMD_LOAD_A) begin
      store_a[it.desc_index*128+it.elem_index] = it.elem_value;
    end else if (it.command == dnrc_pkg::CMD_LOAD_B) begin
      store_b[it.desc_index*128+it.elem_index] = it.elem_value;
    end else if (it.command == dnrc_pkg::CMD_QUERY) begin
      ok = 0;
      nn = 0;
      if (it.desc_index < rows_a && rows_b > 0) begin
        nearest(1, it.desc_index, rows_b, nn, d1, h2, d2);
        ok = 1;
        if (cross_on) begin
          nearest(0, nn, rows_a, back, e1, g2, e2);
          if (back != it.desc_index) ok = 0;
        end
        if (ok && ratio_on && h2 && d1 * 65536 > longint'(ratio_lim) * d2) ok = 0;
      end
      res.matched = ok;
      res.query_index = it.desc_index;
      res.match_index = nn[9:0];
      pending.insert(pending.size(), res);
    end
  endfunction

  function void check_result(dnrc_pkg::out_item_t got);
    dnrc_pkg::out_item_t exp_res;
    if (pending.size() == 0) begin
      $error("unexpected result beat %h", got);
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    if (got.matched !== exp_res.matched) begin
      $error("matched: expected %0d actual %0d", exp_res.matched, got.matched);
      errors++;
    end
    if (got.query_index !== exp_res.query_index) begin
      $error("query_index: expected %0d actual %0d", exp_res.query_index,
             got.query_index);
      errors++;
    end
    if (got.match_index !== exp_res.match_index) begin
      $error("match_index: expected %0d actual %0d", exp_res.match_index,
             got.match_index);
      errors++;
    end
  endfunction
endclass

module tb;
  import dnrc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  match_scoreboard sb;
  bit hold_out = 0;
  int idle_cycles = 0;
  // Rows in use during random phases: only rows loaded by the directed part.
  int na_cur, nb_cur;

  localparam int WatchdogLimit = 400000;

  descriptor_nn_ratio_crosscheck_match_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one input beat and wait until it is taken. Valid stays high after
  // the accepting edge until the next beat, a gap, or another task drops it.
  task automatic send_beat(logic [1:0] cmd, logic [9:0] row, logic [6:0] el,
                           logic [7:0] val, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_data <= '{command: cmd, desc_index: row, elem_index: el, elem_value: val};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    in_valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  // Wait for every expected result, then let any trailing work drain.
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic load_row(bit to_b, int row, int mode, bit gaps);
    logic [7:0] v;
    for (int k = 0; k < 128; k++) begin
      case (mode)
        0: v = 8'd0;
        1: v = 8'hFF;
        default: v = $urandom_range(0, 255);
      endcase
      send_beat(to_b ? CMD_LOAD_B : CMD_LOAD_A, row[9:0], k[6:0], v, gaps);
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    int g;
    if (hold_out) begin
      out_ready <= 0;
    end else begin
      g = gap_len();
      out_ready <= (g == 0);
    end
  end

  // Results are checked before a same-cycle input beat is noted.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (!rst && in_valid && in_ready) sb.note_input(in_data);
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int cmd_pick;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes of element values, row and element indices.
    write_reg(REG_COUNT_A, 16'd2);
    write_reg(REG_COUNT_B, 16'd2);
    load_row(0, 0, 0, 0);
    load_row(0, 1, 1, 0);
    load_row(1, 0, 1, 0);
    load_row(1, 1, 0, 0);
    send_beat(CMD_LOAD_A, 10'd1023, 7'd127, 8'hA5, 0);
    send_beat(CMD_LOAD_B, 10'd1023, 7'd127, 8'h5A, 0);
    send_beat(CMD_NOP, 10'h3FF, 7'h7F, 8'hFF, 0);
    // Zero distances on both sides, then mutual match.
    send_beat(CMD_QUERY, 10'd0, 7'd0, 8'd0, 0);
    send_beat(CMD_QUERY, 10'd1, 7'd127, 8'd255, 0);
    // Query row beyond count_a.
    send_beat(CMD_QUERY, 10'd1023, 7'd0, 8'd0, 0);
    drain();
    // Empty set B.
    write_reg(REG_COUNT_B, 16'd0);
    send_beat(CMD_QUERY, 10'd0, 7'd0, 8'd0, 0);
    drain();
    // Single candidate in B, ratio limit extremes, counts above the row limit.
    write_reg(REG_COUNT_B, 16'd1);
    write_reg(REG_RATIO_SQ, 16'd0);
    send_beat(CMD_QUERY, 10'd1, 7'd0, 8'd0, 0);
    drain();
    write_reg(REG_CROSS_CHECK, 16'hFFFE);
    write_reg(REG_RATIO_ON, 16'h0001);
    write_reg(REG_COUNT_B, 16'd2);
    write_reg(REG_RATIO_SQ, 16'hFFFF);
    send_beat(CMD_QUERY, 10'd0, 7'd0, 8'd0, 0);
    drain();
    write_reg(REG_COUNT_A, 16'h07FF);
    write_reg(REG_COUNT_B, 16'd2);
    send_beat(CMD_QUERY, 10'd1, 7'd0, 8'd0, 0);
    drain();

    // Random phases over the loaded rows: mixed queries, rewrites and noise.
    for (int ph = 0; ph < 4; ph++) begin
      na_cur = $urandom_range(1, 2);
      nb_cur = $urandom_range(1, 2);
      write_reg(REG_COUNT_A, 16'(na_cur));
      write_reg(REG_COUNT_B, 16'(nb_cur));
      write_reg(REG_CROSS_CHECK, 16'($urandom_range(0, 1)));
      write_reg(REG_RATIO_ON, 16'($urandom_range(0, 1)));
      write_reg(REG_RATIO_SQ, (ph == 0) ? 16'd0 : (ph == 3) ? 16'hFFFF
                                                : 16'($urandom_range(0, 65535)));
      if (ph == 1) begin
        // Hold off the receiver while queries keep arriving.
        fork
          begin
            hold_out = 1;
            repeat (3000) @(negedge clk);
            hold_out = 0;
          end
          for (int q = 0; q < 8; q++)
            send_beat(CMD_QUERY, 10'($urandom_range(0, na_cur - 1)), 7'd0, 8'd0, 0);
        join
      end
      for (int i = 0; i < 25; i++) begin
        cmd_pick = $urandom_range(0, 9);
        if (cmd_pick < 6) begin
          send_beat(CMD_QUERY, 10'($urandom_range(0, na_cur)),
                    7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 1);
        end else if (cmd_pick < 9) begin
          // Rewrite an element of a row in use.
          send_beat(cmd_pick[0] ? CMD_LOAD_B : CMD_LOAD_A,
                    10'($urandom_range(0, cmd_pick[0] ? nb_cur - 1 : na_cur - 1)),
                    7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 1);
        end else begin
          send_beat(CMD_NOP, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), 1);
        end
      end
      // Sender pauses until every result is back.
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
